>>> src/pidr_pkg.sv
// Shared types, constants and helpers for the PI distance regulator drive.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pidr_pkg;

   typedef logic        [15:0] dist_type;
   typedef logic signed [11:0] speed_type;
   typedef logic        [7:0]  goal_type;
   typedef logic        [12:0] window_type;
   typedef logic        [7:0]  thresh_type;
   typedef logic        [14:0] bound_type;
   typedef logic        [11:0] gain_type;
   typedef logic signed [15:0] integ_type;
   typedef logic signed [13:0] err_type;
   typedef logic signed [23:0] quot_type;

   localparam int CSR_DATA_W  = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int DIV_SHIFT   = 6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GOAL_DISTANCE   = 3'd0,
      CSR_MIN_DISTANCE    = 3'd1,
      CSR_MAX_DISTANCE    = 3'd2,
      CSR_ERROR_THRESHOLD = 3'd3,
      CSR_MAX_INTEGRAL    = 3'd4,
      CSR_GAIN_PROP       = 3'd5,
      CSR_GAIN_INTEG      = 3'd6
   } csr_index_type;

   localparam goal_type   GOAL_RESET   = 8'd100;
   localparam window_type MIN_RESET    = 13'd20;
   localparam window_type MAX_RESET    = 13'd500;
   localparam thresh_type THRESH_RESET = 8'd10;
   localparam bound_type  BOUND_RESET  = 15'd4000;
   localparam gain_type   KP_RESET     = 12'd160;
   localparam gain_type   KI_RESET     = 12'd56;

   localparam quot_type SPEED_LIMIT = 24'sd1100;

   // Clip a wide signed value to the motor speed range.
   function automatic speed_type sat_speed(input quot_type v);
      speed_type r;
      if (v > SPEED_LIMIT) begin
         r = SPEED_LIMIT[11:0];
      end else if (v < -SPEED_LIMIT) begin
         r = speed_type'(-SPEED_LIMIT);
      end else begin
         r = v[11:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/pidr_req_if.sv
// Request channel: distance, steering offset and sleep flag.
// Depends on pidr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pidr_req_if;
   import pidr_pkg::*;

   logic      valid;
   logic      ready;
   dist_type  distance_mm;
   speed_type steer;
   logic      sleep;

   modport source (output valid, distance_mm, steer, sleep, input ready);
   modport sink   (input valid, distance_mm, steer, sleep, output ready);
endinterface

`default_nettype wire

>>> src/pidr_rsp_if.sv
// Response channel: motor speeds, drive and deadband flag.
// Depends on pidr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pidr_rsp_if;
   import pidr_pkg::*;

   logic      valid;
   logic      ready;
   speed_type right_speed;
   speed_type left_speed;
   speed_type drive;
   logic      in_deadband;

   modport source (output valid, right_speed, left_speed, drive, in_deadband, input ready);
   modport sink   (input valid, right_speed, left_speed, drive, in_deadband, output ready);
endinterface

`default_nettype wire

>>> src/pi_distance_regulator_drive_unit.sv
// PI distance regulator drive: a request passes the input register, the integral stage into
// the mid register, and multiply/saturate into the output register that drives the response.
// Throughput one request per cycle unless the response channel stalls; the integral register
// is read and written in one stage, so consecutive requests see each other's update with no gap.
// Synchronous active-high reset clears the pipeline and the integral and loads CSR defaults.
// Depends on pidr_pkg, pidr_req_if and pidr_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module pi_distance_regulator_drive_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   pidr_req_if.sink                            req_chan,
   pidr_rsp_if.source                          rsp_chan,
   input  wire                                 csr_we,
   input  wire [pidr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [pidr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pidr_pkg::*;

   // configuration
   goal_type   goal_ff;
   window_type min_ff;
   window_type max_ff;
   thresh_type thresh_ff;
   bound_type  bound_ff;
   gain_type   kp_ff;
   gain_type   ki_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff   <= GOAL_RESET;
         min_ff    <= MIN_RESET;
         max_ff    <= MAX_RESET;
         thresh_ff <= THRESH_RESET;
         bound_ff  <= BOUND_RESET;
         kp_ff     <= KP_RESET;
         ki_ff     <= KI_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GOAL_DISTANCE:   goal_ff   <= csr_wdata[7:0];
            CSR_MIN_DISTANCE:    min_ff    <= csr_wdata[12:0];
            CSR_MAX_DISTANCE:    max_ff    <= csr_wdata[12:0];
            CSR_ERROR_THRESHOLD: thresh_ff <= csr_wdata[7:0];
            CSR_MAX_INTEGRAL:    bound_ff  <= csr_wdata[14:0];
            CSR_GAIN_PROP:       kp_ff     <= csr_wdata[11:0];
            CSR_GAIN_INTEG:      ki_ff     <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // pipeline flow control
   logic in_valid_ff, mid_valid_ff, out_valid_ff;
   logic in_ready, mid_ready, out_ready;

   assign out_ready = !out_valid_ff || rsp_chan.ready;
   assign mid_ready = !mid_valid_ff || out_ready;
   assign in_ready  = !in_valid_ff || mid_ready;
   assign req_chan.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready)  in_valid_ff  <= req_chan.valid;
         if (mid_ready) mid_valid_ff <= in_valid_ff;
         if (out_ready) out_valid_ff <= mid_valid_ff;
      end
   end

   // input register
   dist_type  dist_ff;
   speed_type steer_ff;
   logic      sleep_ff;

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         dist_ff  <= req_chan.distance_mm;
         steer_ff <= req_chan.steer;
         sleep_ff <= req_chan.sleep;
      end
   end

   // integral stage: window, error, deadband, clamped accumulate
   logic                out_window;
   window_type          dist_sel;
   err_type             err_in;
   err_type             mag;
   logic                dead_in;
   logic signed [16:0]  acc_sum;
   logic signed [16:0]  bound_pos;
   integ_type           integ_in;
   integ_type           integ_ff;

   assign out_window = (dist_ff > {3'b000, max_ff}) || (dist_ff < {3'b000, min_ff});
   // inside the window the distance is at most max_distance, so 13 bits hold it
   assign dist_sel   = out_window ? {5'b00000, goal_ff} : dist_ff[12:0];
   assign err_in     = $signed({1'b0, dist_sel}) - $signed({6'b000000, goal_ff});
   assign mag        = err_in[13] ? -err_in : err_in;
   assign dead_in    = mag < $signed({6'b000000, thresh_ff});

   assign acc_sum   = {integ_ff[15], integ_ff} + {{3{err_in[13]}}, err_in};
   assign bound_pos = $signed({2'b00, bound_ff});

   always_comb begin
      if (acc_sum > bound_pos) begin
         integ_in = bound_pos[15:0];
      end else if (acc_sum < -bound_pos) begin
         integ_in = integ_type'(-bound_pos);
      end else begin
         integ_in = acc_sum[15:0];
      end
   end

   logic      update_integ;
   assign update_integ = in_valid_ff && mid_ready && !sleep_ff && !dead_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (update_integ) begin
         integ_ff <= integ_in;
      end
   end

   // mid register
   err_type   err_ff;
   integ_type integ_mid_ff;
   logic      dead_ff;
   logic      sleep_mid_ff;
   speed_type steer_mid_ff;

   always_ff @(posedge clock) begin
      if (mid_ready && in_valid_ff) begin
         err_ff       <= err_in;
         integ_mid_ff <= integ_in;
         dead_ff      <= dead_in;
         sleep_mid_ff <= sleep_ff;
         steer_mid_ff <= steer_ff;
      end
   end

   // drive stage: gains, divide by 64 toward zero, saturate, deadband and sleep zeroing, steering
   logic signed [26:0] prod_p;
   logic signed [28:0] prod_i;
   logic signed [29:0] sum_full;
   logic signed [29:0] sum_adj;
   quot_type           quot;
   speed_type          drive_pi;
   speed_type          drive_in;
   logic signed [12:0] right_sum;
   logic signed [12:0] left_sum;
   speed_type          right_in, left_in;
   logic               deadband_in;

   assign prod_p   = $signed({1'b0, kp_ff}) * err_ff;
   assign prod_i   = $signed({1'b0, ki_ff}) * integ_mid_ff;
   assign sum_full = {{3{prod_p[26]}}, prod_p} + {prod_i[28], prod_i};
   // bias negative sums so the arithmetic shift truncates toward zero
   assign sum_adj  = sum_full + $signed({24'b0, {DIV_SHIFT{sum_full[29]}}});
   assign quot     = sum_adj[29:DIV_SHIFT];
   assign drive_pi = sat_speed(quot);
   assign drive_in = dead_ff ? '0 : drive_pi;

   assign right_sum = {drive_in[11], drive_in} + {steer_mid_ff[11], steer_mid_ff};
   assign left_sum  = {drive_in[11], drive_in} - {steer_mid_ff[11], steer_mid_ff};

   always_comb begin
      if (sleep_mid_ff) begin
         right_in    = '0;
         left_in     = '0;
         deadband_in = 1'b1;
      end else begin
         right_in    = sat_speed({{11{right_sum[12]}}, right_sum});
         left_in     = sat_speed({{11{left_sum[12]}}, left_sum});
         deadband_in = dead_ff;
      end
   end

   // output register
   speed_type right_ff, left_ff, drive_ff;
   logic      deadband_ff;

   always_ff @(posedge clock) begin
      if (out_ready && mid_valid_ff) begin
         right_ff    <= right_in;
         left_ff     <= left_in;
         drive_ff    <= sleep_mid_ff ? '0 : drive_in;
         deadband_ff <= deadband_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.right_speed = right_ff;
   assign rsp_chan.left_speed  = left_ff;
   assign rsp_chan.drive       = drive_ff;
   assign rsp_chan.in_deadband = deadband_ff;

endmodule

`default_nettype wire
